// File: hdl/fafr_pkg.sv
// ----------------------------------------------------------------------------
// fafr_pkg
// Shared types and constants of the page activation frequency and fault
// rate core.
// ----------------------------------------------------------------------------
`default_nettype none

package fafr_pkg;

   localparam int ADDR_W   = 64;
   localparam int PID_W    = 23;
   localparam int TIME_W   = 64;
   localparam int COUNT_W  = 8;
   localparam int WORD_W   = 32;
   localparam int THRESH_W = 9;
   localparam int HASH_W   = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [TIME_W-1:0]  ONE_SECOND_NS = 64'd1000000000;
   localparam logic [29:0]        ONE_SECOND_30 = 30'd1000000000;
   localparam logic [COUNT_W-1:0] SLOT_MAX      = 8'd255;
   localparam logic [WORD_W-1:0]  WORD_MAX      = 32'hFFFF_FFFF;

   localparam logic [THRESH_W-1:0] PROTECT_THRESHOLD_RESET = 9'd3;
   localparam logic [WORD_W-1:0]   THRASH_LIMIT_RESET      = 32'd1000;

   localparam logic [CSR_IDX_W-1:0] REG_PROTECT_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRASH_RATE_LIMIT = 1'd1;

   typedef struct packed {
      logic [WORD_W-1:0] faults;
      logic [TIME_W-1:0] start;
      logic [WORD_W-1:0] rate;
      logic              thrashing;
      logic [WORD_W-1:0] uses;
   } entry_type;

endpackage

`default_nettype wire

// File: hdl/fafr_channels.sv
// ----------------------------------------------------------------------------
// fafr channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fafr_req_if;
   import fafr_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] chunk_address;
   logic [PID_W-1:0]  owner_id;
   logic [TIME_W-1:0] now_ns;
   modport source (output valid, chunk_address, owner_id, now_ns, input ready);
   modport sink   (input valid, chunk_address, owner_id, now_ns, output ready);
endinterface

interface fafr_rsp_if;
   import fafr_pkg::*;
   logic               valid;
   logic               ready;
   logic               protect;
   logic [COUNT_W-1:0] access_count;
   logic               pid_tracked;
   logic [WORD_W-1:0]  rate_out;
   logic               thrashing_out;
   logic [WORD_W-1:0]  uses_out;
   modport source (output valid, protect, access_count, pid_tracked, rate_out,
                   thrashing_out, uses_out, input ready);
   modport sink   (input valid, protect, access_count, pid_tracked, rate_out,
                   thrashing_out, uses_out, output ready);
endinterface

`default_nettype wire

// File: hdl/fafr_div.sv
// ----------------------------------------------------------------------------
// fafr_div
// Restoring 64-bit by 64-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fafr_div
   import fafr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [TIME_W-1:0] dividend,
   input  wire logic [TIME_W-1:0] divisor,
   output logic                   done,
   output logic [TIME_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(TIME_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [TIME_W:0]   rem_ff;
   logic [TIME_W-1:0] quo_ff;
   logic [TIME_W-1:0] div_ff;
   logic [TIME_W:0]   trial;
   logic              take;

   assign trial = {rem_ff[TIME_W-1:0], quo_ff[TIME_W-1]};
   assign take  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff  <= take ? (trial - {1'b0, div_ff}) : trial;
            quo_ff  <= {quo_ff[TIME_W-2:0], take};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(TIME_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: hdl/fafr_slot_mem.sv
// ----------------------------------------------------------------------------
// fafr_slot_mem
// Access counter memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fafr_slot_mem
   import fafr_pkg::*;
#(
   parameter int COUNT_SLOTS = 16384,
   parameter int SLOT_W      = 14
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire logic [SLOT_W-1:0]  rd_addr,
   output logic [COUNT_W-1:0]      rd_data,
   input  wire logic               wr_en,
   input  wire logic [SLOT_W-1:0]  wr_addr,
   input  wire logic [COUNT_W-1:0] wr_data,
   output logic                    clearing
);

   logic [COUNT_W-1:0] mem [COUNT_SLOTS];
   logic [COUNT_W-1:0] rd_data_ff;
   logic               clearing_ff;
   logic [SLOT_W-1:0]  clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clearing_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == SLOT_W'(COUNT_SLOTS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

`default_nettype wire

// File: hdl/page_activate_frequency_and_fault_rate_core.sv
// Flow: a request taken in the idle state passes through the hash, lookup, read,
// evaluate and write states; closing an owner's window adds the product and the
// 64-step divider, and a slot count that is not a power of two adds the hash
// wait and fix states. One request is in flight, and a stalled response holds it.
// After reset the counter memory is cleared one slot at a time, during
// which no request is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// page_activate_frequency_and_fault_rate_core
// Hashed saturating access counters with a per-owner fault rate table.
// ----------------------------------------------------------------------------
`default_nettype none

module page_activate_frequency_and_fault_rate_core
   import fafr_pkg::*;
#(
   parameter int COUNT_SLOTS = 16384,
   parameter int PID_ENTRIES = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   fafr_req_if.sink                  req_bus,
   fafr_rsp_if.source                rsp_bus,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_write_data
);

   localparam int SLOT_W = (COUNT_SLOTS > 1) ? $clog2(COUNT_SLOTS) : 1;
   localparam int IDX_W  = (PID_ENTRIES > 1) ? $clog2(PID_ENTRIES) : 1;
   // A power-of-two slot count lets the hash be reduced by a mask.
   localparam bit SLOT_POW2 = (COUNT_SLOTS & (COUNT_SLOTS - 1)) == 0;
   // Reciprocal of the slot count, rounded down, for the hash reduction.
   localparam logic [HASH_W-1:0] HASH_RECIP = HASH_W'((64'd1 << 32) / COUNT_SLOTS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_HASH, ST_HASH_WAIT, ST_HASH_FIX, ST_LOOKUP, ST_READ, ST_EVAL,
      ST_MUL, ST_DIV_START, ST_DIV_WAIT, ST_WRITE
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [THRESH_W-1:0] protect_threshold_ff;
   logic [WORD_W-1:0]   thrash_rate_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         protect_threshold_ff <= PROTECT_THRESHOLD_RESET;
         thrash_rate_limit_ff <= THRASH_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_PROTECT_THRESHOLD: protect_threshold_ff <= csr_write_data[THRESH_W-1:0];
            REG_THRASH_RATE_LIMIT: thrash_rate_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // The request being worked on.
   logic [ADDR_W-1:0]  addr_ff;
   logic [PID_W-1:0]   pid_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               hit_ff;
   logic               alloc_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               tracked_ff;
   logic               protect_ff;
   logic [COUNT_W-1:0] count_ff;
   entry_type          rec_ff;
   logic [61:0]        product_ff;
   logic [63:0]        hash_prod_ff;
   logic [HASH_W-1:0]  hash_rem_ff;

   // Response register, so that a finished response can wait for the sink.
   logic               rsp_valid_ff;
   logic               rsp_protect_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_tracked_ff;
   logic [WORD_W-1:0]  rsp_rate_ff;
   logic               rsp_thrashing_ff;
   logic [WORD_W-1:0]  rsp_uses_ff;

   // The owner table: valid bits and PIDs in flip-flops for the associative
   // compare, the per-owner figures in a memory indexed by the match.
   logic              entry_valid_ff [PID_ENTRIES];
   logic [PID_W-1:0]  entry_pid_ff   [PID_ENTRIES];
   entry_type         entry_mem      [PID_ENTRIES];
   entry_type         entry_rd_ff;

   logic              hash_hit;
   logic [IDX_W-1:0]  hash_hit_idx;
   logic              has_free;
   logic [IDX_W-1:0]  free_idx;

   always_comb begin
      hash_hit     = 1'b0;
      hash_hit_idx = '0;
      has_free     = 1'b0;
      free_idx     = '0;
      for (int i = PID_ENTRIES - 1; i >= 0; i--) begin
         if (entry_valid_ff[i] && entry_pid_ff[i] == pid_ff) begin
            hash_hit     = 1'b1;
            hash_hit_idx = IDX_W'(i);
         end
         if (!entry_valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // Slot hash: two shifted copies of the address folded into 32 bits.
   logic [HASH_W-1:0] hash_value;
   assign hash_value = addr_ff[6 +: HASH_W] ^ addr_ff[18 +: HASH_W];

   // For a slot count that is not a power of two, the quotient is estimated
   // from the rounded-down reciprocal. The estimate is at most one short, so
   // the remainder is below twice the slot count and one subtraction ends it.
   logic [63:0]       hash_prod;
   logic [HASH_W-1:0] hash_rem;
   logic [SLOT_W-1:0] hash_slot;

   assign hash_prod = 64'(hash_value) * 64'(HASH_RECIP);
   assign hash_rem  = hash_value - HASH_W'(hash_prod_ff[63:32] * HASH_W'(COUNT_SLOTS));
   assign hash_slot = (hash_rem_ff >= HASH_W'(COUNT_SLOTS))
                      ? SLOT_W'(hash_rem_ff - HASH_W'(COUNT_SLOTS)) : SLOT_W'(hash_rem_ff);

   // Divider for the fault rate.
   logic              div_start;
   logic [TIME_W-1:0] div_dividend;
   logic [TIME_W-1:0] div_divisor;
   logic              div_done;
   logic [TIME_W-1:0] div_quotient;

   assign div_start    = state_ff == ST_DIV_START;
   assign div_dividend = {2'b00, product_ff};
   assign div_divisor  = now_ff - rec_ff.start;

   fafr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient)
   );

   // Counter memory.
   logic               slot_rd_en;
   logic [COUNT_W-1:0] slot_rd_data;
   logic               slot_wr_en;
   logic [COUNT_W-1:0] slot_next;
   logic               clearing;

   assign slot_rd_en = state_ff == ST_LOOKUP;
   assign slot_wr_en = state_ff == ST_EVAL;
   assign slot_next  = (slot_rd_data == SLOT_MAX) ? SLOT_MAX : slot_rd_data + 1'b1;

   fafr_slot_mem #(
      .COUNT_SLOTS (COUNT_SLOTS),
      .SLOT_W      (SLOT_W)
   ) u_slot_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (slot_rd_en),
      .rd_addr  (slot_ff),
      .rd_data  (slot_rd_data),
      .wr_en    (slot_wr_en),
      .wr_addr  (slot_ff),
      .wr_data  (slot_next),
      .clearing (clearing)
   );

   // Read-modify-write of the owner figures; one request at a time, so the
   // read in the read state always sees the latest write.
   logic entry_wr_en;
   logic rsp_free;

   assign rsp_free    = !rsp_valid_ff || rsp_bus.ready;
   assign entry_wr_en = state_ff == ST_WRITE && rsp_free && tracked_ff;

   always_ff @(posedge clock) begin
      if (entry_wr_en) begin
         entry_mem[idx_ff] <= rec_ff;
      end
      if (state_ff == ST_READ) begin
         entry_rd_ff <= entry_mem[idx_ff];
      end
   end

   // Figures of an entry that stays open or is updated.
   logic [WORD_W-1:0] faults_inc;
   logic [WORD_W-1:0] uses_inc;
   logic [TIME_W-1:0] elapsed;
   logic [61:0]       product;
   entry_type         rec_hit;

   assign faults_inc = (entry_rd_ff.faults == WORD_MAX) ? WORD_MAX : entry_rd_ff.faults + 1'b1;
   assign uses_inc   = (entry_rd_ff.uses == WORD_MAX) ? WORD_MAX : entry_rd_ff.uses + 1'b1;
   assign elapsed    = now_ff - entry_rd_ff.start;
   assign product    = rec_ff.faults * ONE_SECOND_30;

   always_comb begin
      rec_hit        = entry_rd_ff;
      rec_hit.faults = faults_inc;
      rec_hit.uses   = uses_inc;
   end

   assign req_bus.ready = state_ff == ST_IDLE && !clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PID_ENTRIES; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else begin
         // A response leaving in the write state is replaced there instead.
         if (rsp_valid_ff && rsp_bus.ready && state_ff != ST_WRITE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_bus.valid && !clearing) begin
                  addr_ff  <= req_bus.chunk_address;
                  pid_ff   <= req_bus.owner_id;
                  now_ff   <= req_bus.now_ns;
                  state_ff <= ST_HASH;
               end
            end
            ST_HASH: begin
               if (SLOT_POW2) begin
                  slot_ff  <= hash_value[SLOT_W-1:0];
                  state_ff <= ST_LOOKUP;
               end else begin
                  hash_prod_ff <= hash_prod;
                  state_ff     <= ST_HASH_WAIT;
               end
            end
            ST_HASH_WAIT: begin
               hash_rem_ff <= hash_rem;
               state_ff    <= ST_HASH_FIX;
            end
            ST_HASH_FIX: begin
               slot_ff  <= hash_slot;
               state_ff <= ST_LOOKUP;
            end
            ST_LOOKUP: begin
               // A zero PID is never tracked.
               hit_ff   <= pid_ff != '0 && hash_hit;
               alloc_ff <= pid_ff != '0 && !hash_hit && has_free;
               idx_ff   <= hash_hit ? hash_hit_idx : free_idx;
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               protect_ff <= ({1'b0, slot_rd_data} + 9'd1) >= protect_threshold_ff;
               count_ff   <= slot_next;
               tracked_ff <= hit_ff || alloc_ff;
               state_ff   <= ST_WRITE;
               if (alloc_ff) begin
                  entry_valid_ff[idx_ff] <= 1'b1;
                  entry_pid_ff[idx_ff]   <= pid_ff;
                  rec_ff.faults    <= 32'd1;
                  rec_ff.start     <= now_ff;
                  rec_ff.rate      <= '0;
                  rec_ff.thrashing <= 1'b0;
                  rec_ff.uses      <= 32'd1;
               end else if (hit_ff) begin
                  rec_ff <= rec_hit;
                  // More than a second since the window opened closes it.
                  if (elapsed > ONE_SECOND_NS) begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               product_ff <= product;
               state_ff   <= ST_DIV_START;
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  rec_ff.rate      <= div_quotient[WORD_W-1:0];
                  rec_ff.thrashing <= div_quotient > TIME_W'(thrash_rate_limit_ff);
                  rec_ff.faults    <= '0;
                  rec_ff.start     <= now_ff;
                  state_ff         <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               if (rsp_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_protect_ff   <= protect_ff;
                  rsp_count_ff     <= count_ff;
                  rsp_tracked_ff   <= tracked_ff;
                  rsp_rate_ff      <= tracked_ff ? rec_ff.rate : '0;
                  rsp_thrashing_ff <= tracked_ff && rec_ff.thrashing;
                  rsp_uses_ff      <= tracked_ff ? rec_ff.uses : '0;
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.protect       = rsp_protect_ff;
   assign rsp_bus.access_count  = rsp_count_ff;
   assign rsp_bus.pid_tracked   = rsp_tracked_ff;
   assign rsp_bus.rate_out      = rsp_rate_ff;
   assign rsp_bus.thrashing_out = rsp_thrashing_ff;
   assign rsp_bus.uses_out      = rsp_uses_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page activation frequency and fault rate core.
// A directed table covers the reset state, the extremes of the fields and
// each special case. Random phases follow that work over a small pool of
// owners and addresses. Every response is checked field by field against an
// internal predictor of the counters and the owner table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import fafr_pkg::*;

   localparam int SLOTS   = 16384;
   localparam int ENTRIES = 64;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [PID_W-1:0]  pid;
      logic [TIME_W-1:0] now;
      bit                has_exp;
      logic              protect;
      logic [COUNT_W-1:0] count;
   } stim_row;

   typedef struct packed {
      logic               protect;
      logic [COUNT_W-1:0] count;
      logic               tracked;
      logic [WORD_W-1:0]  rate;
      logic               thrashing;
      logic [WORD_W-1:0]  uses;
   } activation_result;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_write_data = '0;

   fafr_req_if req_bus ();
   fafr_rsp_if rsp_bus ();

   page_activate_frequency_and_fault_rate_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus.sink),
      .rsp_bus          (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow of the block's state, updated in request order.
   logic [COUNT_W-1:0]  shadow_counts [SLOTS];
   bit                  owner_valid   [ENTRIES];
   logic [PID_W-1:0]    owner_key     [ENTRIES];
   logic [WORD_W-1:0]   owner_faults  [ENTRIES];
   logic [TIME_W-1:0]   owner_start   [ENTRIES];
   logic [WORD_W-1:0]   owner_rate    [ENTRIES];
   logic                owner_thrash  [ENTRIES];
   logic [WORD_W-1:0]   owner_uses    [ENTRIES];
   logic [THRESH_W-1:0] shadow_threshold;
   logic [WORD_W-1:0]   shadow_limit;

   activation_result expected_results[$];
   int  error_count = 0;
   int  result_count = 0;
   int  protected_seen = 0;
   int  thrash_seen = 0;
   bit  long_hold = 1'b0;

   // Works out the response to one request and moves the shadow state on.
   function automatic activation_result predict_activation(
      input logic [ADDR_W-1:0] addr, input logic [PID_W-1:0] pid,
      input logic [TIME_W-1:0] now);
      activation_result r;
      int e;
      logic [TIME_W-1:0] elapsed;
      logic [127:0] rate_wide;
      logic [31:0] h;
      int slot;
      logic [8:0] old_plus;
      r = '0;
      e = -1;
      if (pid != '0) begin
         for (int i = 0; i < ENTRIES; i++)
            if (e < 0 && owner_valid[i] && owner_key[i] == pid) e = i;
         if (e >= 0) begin
            if (owner_faults[e] != WORD_MAX) owner_faults[e]++;
            elapsed = now - owner_start[e];
            if (elapsed > ONE_SECOND_NS) begin
               rate_wide = ({96'd0, owner_faults[e]} * 128'd1000000000) / {64'd0, elapsed};
               owner_rate[e]   = rate_wide[31:0];
               owner_thrash[e] = rate_wide > {96'd0, shadow_limit};
               owner_faults[e] = '0;
               owner_start[e]  = now;
            end
         end else begin
            for (int i = 0; i < ENTRIES; i++)
               if (e < 0 && !owner_valid[i]) e = i;
            if (e >= 0) begin
               owner_valid[e]  = 1'b1;
               owner_key[e]    = pid;
               owner_faults[e] = 32'd1;
               owner_start[e]  = now;
               owner_rate[e]   = '0;
               owner_thrash[e] = 1'b0;
               owner_uses[e]   = '0;
            end
         end
         if (e >= 0) begin
            if (owner_uses[e] != WORD_MAX) owner_uses[e]++;
            r.tracked   = 1'b1;
            r.rate      = owner_rate[e];
            r.thrashing = owner_thrash[e];
            r.uses      = owner_uses[e];
         end
      end
      h = addr[37:6] ^ addr[49:18];
      slot = int'(h % SLOTS);
      old_plus = {1'b0, shadow_counts[slot]} + 9'd1;
      if (shadow_counts[slot] != SLOT_MAX) shadow_counts[slot]++;
      r.count   = shadow_counts[slot];
      r.protect = old_plus >= shadow_threshold;
      return r;
   endfunction

   // Register writes happen only while nothing is in flight.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == REG_PROTECT_THRESHOLD) shadow_threshold = value[THRESH_W-1:0];
      else shadow_limit = value;
   endtask

   // Waits for every outstanding response, then for the longest latency.
   task automatic drain_responses();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // Offers one request, with an optional random gap first, and predicts at acceptance.
   task automatic send_activation(input logic [ADDR_W-1:0] addr,
                                  input logic [PID_W-1:0] pid,
                                  input logic [TIME_W-1:0] now,
                                  input bit use_gap);
      int gap;
      gap = use_gap ? $urandom_range(7, 0) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.chunk_address <= addr;
      req_bus.owner_id      <= pid;
      req_bus.now_ns        <= now;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(predict_activation(addr, pid, now));
   endtask

   task automatic idle_request();
      req_bus.valid <= 1'b0;
   endtask

   // Response side: random stalls per response, plus one long hold-off.
   initial begin
      int stall;
      activation_result got, want;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         stall = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(7, 0);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.protect   = rsp_bus.protect;
         got.count     = rsp_bus.access_count;
         got.tracked   = rsp_bus.pid_tracked;
         got.rate      = rsp_bus.rate_out;
         got.thrashing = rsp_bus.thrashing_out;
         got.uses      = rsp_bus.uses_out;
         result_count++;
         if (got.protect) protected_seen++;
         if (got.thrashing) thrash_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: response with nothing expected: %p", $time, got);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
               error_count++;
            end
         end
      end
   end

   // Stimulus and phases.
   initial begin
      stim_row directed[$];
      stim_row row;
      logic [PID_W-1:0]  pids [8];
      logic [ADDR_W-1:0] addrs [6];
      logic [TIME_W-1:0] clock_ns [8];
      logic [ADDR_W-1:0] a;
      logic [PID_W-1:0]  p;
      int k;

      req_bus.valid = 1'b0;
      req_bus.chunk_address = '0;
      req_bus.owner_id = '0;
      req_bus.now_ns = '0;
      foreach (shadow_counts[i]) shadow_counts[i] = '0;
      foreach (owner_valid[i]) owner_valid[i] = 1'b0;
      shadow_threshold = PROTECT_THRESHOLD_RESET;
      shadow_limit     = THRASH_LIMIT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table: rows with has_exp carry counts read off by hand.
      // The all-ones address folds to the same slot as address zero.
      directed = '{
         '{64'h0, 23'd0, 64'h0, 1'b1, 1'b0, 8'd1},
         '{64'h0, 23'd0, 64'h0, 1'b1, 1'b0, 8'd2},
         '{64'h0, 23'd0, 64'h0, 1'b1, 1'b1, 8'd3},
         '{64'hFFFF_FFFF_FFFF_FFFF, 23'h7F_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 8'd4},
         '{64'hFFFF_FFFF_FFFF_FFFF, 23'h7F_FFFF, 64'd5, 1'b0, 1'b0, 8'd0},
         '{64'h40, 23'd1, 64'd0, 1'b0, 1'b0, 8'd0},
         '{64'h40, 23'd1, 64'd500, 1'b0, 1'b0, 8'd0},
         '{64'h40, 23'd1, 64'd1000000000, 1'b0, 1'b0, 8'd0},
         '{64'h40, 23'd1, 64'd1000000001, 1'b0, 1'b0, 8'd0},
         '{64'h40, 23'd1, 64'd10, 1'b0, 1'b0, 8'd0},
         '{64'hAAAA_5555_AAAA_5555, 23'h2A_AAAA, 64'h5555_AAAA_5555_AAAA, 1'b0, 1'b0, 8'd0},
         '{64'h5555_AAAA_5555_AAAA, 23'h55_5555, 64'hAAAA_5555_AAAA_5555, 1'b0, 1'b0, 8'd0}
      };
      // Wait out the clearing pass behind the ready handshake.
      foreach (directed[i]) begin
         row = directed[i];
         send_activation(row.addr, row.pid, row.now, 1'b1);
         if (row.has_exp && (expected_results[$].count !== row.count ||
                             expected_results[$].protect !== row.protect)) begin
            $display("%0t: directed row %0d expected count %0d protect %0b, predicted %0d %0b",
                     $time, i, row.count, row.protect,
                     expected_results[$].count, expected_results[$].protect);
            error_count++;
         end
      end
      idle_request();
      drain_responses();

      // Saturate one slot with a zero threshold, then a threshold of 256.
      write_register(REG_PROTECT_THRESHOLD, 32'd0);
      write_register(REG_THRASH_RATE_LIMIT, 32'd0);
      for (int i = 0; i < 260; i++)
         send_activation(64'h1000, 23'd7, 64'(i) * 64'd400000000, i % 4 == 0);
      idle_request();
      drain_responses();
      write_register(REG_PROTECT_THRESHOLD, 32'd256);
      write_register(REG_THRASH_RATE_LIMIT, 32'hFFFF_FFFF);
      send_activation(64'h1000, 23'd7, 64'hFFFF_FFFF_0000_0000, 1'b0);
      send_activation(64'h1040, 23'd7, 64'd3, 1'b0);

      // Fill the owner table, then show that further new owners are turned away.
      for (int i = 0; i < ENTRIES + 2; i++)
         send_activation(64'(i) << 6, 23'd100 + 23'(i), 64'd0, 1'b1);
      idle_request();
      drain_responses();

      // Random phases over a small pool so owners and slots recur.
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               write_register(REG_PROTECT_THRESHOLD, 32'd1);
               write_register(REG_THRASH_RATE_LIMIT, 32'd2);
            end
            1: begin
               write_register(REG_PROTECT_THRESHOLD, 32'd5);
               write_register(REG_THRASH_RATE_LIMIT, 32'd1000);
            end
            default: begin
               write_register(REG_PROTECT_THRESHOLD, 32'($urandom_range(256, 1)));
               write_register(REG_THRASH_RATE_LIMIT, $urandom);
            end
         endcase
         foreach (pids[i]) begin
            pids[i] = (i < 5) ? 23'd100 + 23'($urandom_range(63, 0)) : 23'($urandom);
            clock_ns[i] = {$urandom, $urandom};
         end
         pids[0] = '0;
         foreach (addrs[i]) addrs[i] = {$urandom, $urandom};
         for (int n = 0; n < 40; n++) begin
            if (ph == 1 && n == 10) long_hold = 1'b1;
            if (ph == 2 && n == 20) begin
               idle_request();
               while (expected_results.size() != 0) @(posedge clock);
            end
            k = $urandom_range(7, 0);
            a = ($urandom_range(3, 0) == 0) ? {$urandom, $urandom}
                                            : addrs[$urandom_range(5, 0)];
            p = pids[k];
            case ($urandom_range(5, 0))
               0:       clock_ns[k] = {$urandom, $urandom};
               1, 2:    clock_ns[k] += 64'($urandom_range(1200000000, 900000000));
               default: clock_ns[k] += 64'($urandom_range(400000000, 0));
            endcase
            send_activation(a, p, clock_ns[k], n % 20 < 15);
         end
         idle_request();
         drain_responses();
      end

      $display("Run covered %0d responses, %0d protected, %0d with a thrashing owner,",
               result_count, protected_seen, thrash_seen);
      $display("including a full owner table, a saturated slot and the register extremes.");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("%0d errors, %0d responses outstanding", error_count,
                  expected_results.size());
         $display("tb_top: errors");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5ms;
      $display("%0t: timeout", $time);
      $display("tb_top: errors");
      $finish;
   end

endmodule

`default_nettype wire
